FILE: rtl/text_to_multiword_integer_core_macros.svh
// Assertion helpers shared by the checker. Every property is sampled on the
// rising edge of clock and is switched off while reset is high.
`ifndef TEXT_TO_MULTIWORD_INTEGER_CORE_MACROS_SVH
`define TEXT_TO_MULTIWORD_INTEGER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTMI_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTMI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ttmi_pkg.sv
package ttmi_pkg;

   localparam int CHAR_W        = 8;
   localparam int WORD_W        = 32;
   localparam int IDX_W         = 3;
   localparam int CNT_W         = 4;
   localparam int CFG_W         = 4;
   localparam int DIGIT_W       = 4;
   // A pending carry between two cells never exceeds sixteen.
   localparam int CARRY_W       = 5;
   localparam int SUM_W         = WORD_W + 1;
   localparam int PROD_W        = WORD_W + CARRY_W;
   localparam int MAX_OUT_WORDS = 8;
   localparam int DEFAULT_WORDS = 8;
   localparam logic [CFG_W-1:0] RESET_ACTIVE_WORDS = 4'd8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [DIGIT_W-1:0] TEN         = 4'd10;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_DEC,
      OP_HEX
   } ttmi_op_type;

   // Per-cell control for one accepted character.
   typedef struct packed {
      logic                step;
      logic                active;
      logic                top;
      logic                clear;
      ttmi_op_type         op;
      logic [DIGIT_W-1:0]  digit;
   } ttmi_ctrl_type;

   typedef struct packed {
      logic busy;
      logic ending;
   } ttmi_drain_status_type;

endpackage

FILE: rtl/ttmi_channels.sv
interface ttmi_req_if;
   import ttmi_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              is_final;

   modport source (output valid, output character, output is_final, input ready);
   modport sink   (input valid, input character, input is_final, output ready);
endinterface

interface ttmi_rsp_if;
   import ttmi_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_value;
   logic [IDX_W-1:0]  word_index;
   logic              last_word;

   modport source (output valid, output word_value, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input word_value, input word_index, input last_word,
                   output ready);
endinterface

FILE: rtl/ttmi_cell.sv
module ttmi_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  ttmi_pkg::ttmi_ctrl_type        ctrl,
   input  logic [ttmi_pkg::CARRY_W-1:0]   carry_below,
   output logic [ttmi_pkg::CARRY_W-1:0]   carry_out,
   output logic [ttmi_pkg::WORD_W-1:0]    next_word,
   output logic [ttmi_pkg::CARRY_W-1:0]   next_carry
);
   import ttmi_pkg::*;

   // The value is held in carry-save form: the word plus the carry that the
   // cell below produced at the previous step.
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [SUM_W-1:0]   sum;
   logic [PROD_W-1:0]  sum_ext;
   logic [PROD_W-1:0]  prod;
   logic [WORD_W-1:0]  folded_word;

   always_comb begin
      sum     = {1'b0, word_ff} + {{(SUM_W-CARRY_W){1'b0}}, carry_ff};
      sum_ext = {{(PROD_W-SUM_W){1'b0}}, sum};
      case (ctrl.op)
         OP_DEC:  prod = (sum_ext << 3) + (sum_ext << 1)
                         + {{(PROD_W-DIGIT_W){1'b0}}, ctrl.digit};
         OP_HEX:  prod = (sum_ext << 4) + {{(PROD_W-DIGIT_W){1'b0}}, ctrl.digit};
         default: prod = '0;
      endcase
      carry_out   = prod[PROD_W-1:WORD_W];
      folded_word = prod[WORD_W-1:0] + {{(WORD_W-CARRY_W){1'b0}}, carry_below};

      // The top active cell keeps its word resolved, so nothing above the active
      // width survives into a later step with a larger word count.
      next_word  = word_ff;
      next_carry = carry_ff;
      if (ctrl.step) begin
         if (!ctrl.active) begin
            next_word  = '0;
            next_carry = '0;
         end else if (ctrl.op != OP_HOLD) begin
            if (ctrl.top) begin
               next_word  = folded_word;
               next_carry = '0;
            end else begin
               next_word  = prod[WORD_W-1:0];
               next_carry = carry_below;
            end
         end else if (ctrl.top) begin
            next_word  = sum[WORD_W-1:0];
            next_carry = '0;
         end
      end

      word_in  = ctrl.clear ? '0 : next_word;
      carry_in = ctrl.clear ? '0 : next_carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         carry_ff <= '0;
      end else begin
         word_ff  <= word_in;
         carry_ff <= carry_in;
      end
   end

endmodule

FILE: rtl/ttmi_drain.sv
module ttmi_drain #(
   parameter int CELLS = ttmi_pkg::MAX_OUT_WORDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [ttmi_pkg::WORD_W-1:0]         load_word [CELLS],
   input  logic [ttmi_pkg::CARRY_W-1:0]        load_carry [CELLS],
   input  logic [ttmi_pkg::IDX_W-1:0]          load_last,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic [ttmi_pkg::WORD_W-1:0]         out_word,
   output logic [ttmi_pkg::IDX_W-1:0]          out_index,
   output logic                                out_last,
   output ttmi_pkg::ttmi_drain_status_type     status
);
   import ttmi_pkg::*;

   logic [WORD_W-1:0]  word_ff [CELLS];
   logic [CARRY_W-1:0] carry_ff [CELLS];
   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic               ripple_ff, ripple_in;
   logic [SUM_W-1:0]   head_sum;
   logic               transfer;

   // The carry-save words are resolved here, one word per transfer, with a
   // single ripple bit carried from one word to the next.
   always_comb begin
      head_sum  = {1'b0, word_ff[0]} + {{(SUM_W-CARRY_W){1'b0}}, carry_ff[0]}
                  + {{(SUM_W-1){1'b0}}, ripple_ff};
      transfer  = busy_ff && out_ready;
      out_valid = busy_ff;
      out_word  = head_sum[WORD_W-1:0];
      out_index = idx_ff;
      out_last  = (idx_ff == last_ff);
      status.busy   = busy_ff;
      status.ending = transfer && out_last;

      busy_in   = busy_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      ripple_in = ripple_ff;
      if (load) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         last_in   = load_last;
         ripple_in = 1'b0;
      end else if (transfer) begin
         busy_in   = !out_last;
         idx_in    = idx_ff + IDX_W'(1);
         ripple_in = head_sum[WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff  <= load_word;
         carry_ff <= load_carry;
      end else if (transfer) begin
         for (int k = 0; k < CELLS - 1; k++) begin
            word_ff[k]  <= word_ff[k+1];
            carry_ff[k] <= carry_ff[k+1];
         end
         word_ff[CELLS-1]  <= '0;
         carry_ff[CELLS-1] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         idx_ff    <= '0;
         last_ff   <= '0;
         ripple_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         idx_ff    <= idx_in;
         last_ff   <= last_in;
         ripple_ff <= ripple_in;
      end
   end

endmodule

FILE: rtl/text_to_multiword_integer_core.sv
// Channel   Direction  Payload                                  Handshake
// req       in         character[7:0], is_final                 valid/ready
// rsp       out        word_value[31:0], word_index[2:0], last  valid/ready
// csr       in         csr_write_data[3:0] (active words)       write enable
//
// One character is taken per cycle; the row of word cells updates in that cycle.
// A final character loads the drain buffer, which gives one word per cycle for
// the active word count while rsp.ready is high.
// A final character waits while the drain buffer still holds earlier words.
// Reset is synchronous: value cleared, decimal mode, eight active words.
module text_to_multiword_integer_core #(
   parameter int WORDS = ttmi_pkg::DEFAULT_WORDS
) (
   input  logic                         clock,
   input  logic                         reset,
   ttmi_req_if.sink                     req,
   ttmi_rsp_if.source                   rsp,
   input  logic                         csr_write_enable,
   input  logic [ttmi_pkg::CFG_W-1:0]   csr_write_data
);
   import ttmi_pkg::*;

   localparam int CELLS = (WORDS < MAX_OUT_WORDS) ? WORDS : MAX_OUT_WORDS;
   localparam logic [CNT_W-1:0] CELLS_N = CNT_W'(CELLS);

   logic [CFG_W-1:0]   active_words_ff;
   logic [1:0]         position_ff, position_in;
   logic               hex_mode_ff, hex_mode_in;
   logic               first_zero_ff, first_zero_in;

   logic               accept, finish;
   logic [CNT_W-1:0]   word_count;
   logic [CHAR_W-1:0]  ch;
   logic [CHAR_W-1:0]  dec_offset, upper_offset, lower_offset;
   logic               is_prefix_x;
   logic               dec_valid, hex_valid;
   logic [DIGIT_W-1:0] dec_digit, hex_digit;
   ttmi_op_type        op;
   logic [DIGIT_W-1:0] digit;

   ttmi_ctrl_type         ctrl [CELLS];
   logic [CARRY_W-1:0]    carries [CELLS];
   logic [WORD_W-1:0]     snap_word [CELLS];
   logic [CARRY_W-1:0]    snap_carry [CELLS];
   ttmi_drain_status_type drain_st;

   always_comb begin
      ch           = req.character;
      dec_offset   = ch - CHAR_ZERO;
      upper_offset = ch - CHAR_UPPER_A;
      lower_offset = ch - CHAR_LOWER_A;

      dec_valid = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      dec_digit = dec_offset[DIGIT_W-1:0];

      hex_valid = 1'b1;
      if (dec_valid) begin
         hex_digit = dec_digit;
      end else if ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_F)) begin
         hex_digit = upper_offset[DIGIT_W-1:0] + TEN;
      end else if ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_F)) begin
         hex_digit = lower_offset[DIGIT_W-1:0] + TEN;
      end else begin
         hex_valid = 1'b0;
         hex_digit = '0;
      end

      is_prefix_x = (position_ff == 2'd1) && first_zero_ff
                    && ((ch == CHAR_LOWER_X) || (ch == CHAR_UPPER_X));

      if (active_words_ff == '0) begin
         word_count = CNT_W'(1);
      end else if (active_words_ff > CELLS_N) begin
         word_count = CELLS_N;
      end else begin
         word_count = active_words_ff;
      end

      // A final character needs the drain buffer free by the next edge.
      req.ready = !req.is_final || !drain_st.busy || drain_st.ending;
      accept    = req.valid && req.ready;
      finish    = accept && req.is_final;

      op    = OP_HOLD;
      digit = '0;
      if (is_prefix_x) begin
         op = OP_HOLD;
      end else if (hex_mode_ff) begin
         if (hex_valid) begin
            op    = OP_HEX;
            digit = hex_digit;
         end
      end else if (dec_valid) begin
         op    = OP_DEC;
         digit = dec_digit;
      end

      position_in   = position_ff;
      hex_mode_in   = hex_mode_ff;
      first_zero_in = first_zero_ff;
      if (finish) begin
         position_in   = '0;
         hex_mode_in   = 1'b0;
         first_zero_in = 1'b0;
      end else if (accept) begin
         if (position_ff != 2'd2) begin
            position_in = position_ff + 2'd1;
         end
         if (is_prefix_x) begin
            hex_mode_in = 1'b1;
         end else if (!hex_mode_ff && (position_ff == 2'd0)) begin
            first_zero_in = (ch == CHAR_ZERO);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_words_ff <= RESET_ACTIVE_WORDS;
         position_ff     <= '0;
         hex_mode_ff     <= 1'b0;
         first_zero_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            active_words_ff <= csr_write_data;
         end
         position_ff   <= position_in;
         hex_mode_ff   <= hex_mode_in;
         first_zero_ff <= first_zero_in;
      end
   end

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      logic [CARRY_W-1:0] cin;

      always_comb begin
         ctrl[j].step   = accept;
         ctrl[j].active = (CNT_W'(j) < word_count);
         ctrl[j].top    = (CNT_W'(j) == (word_count - CNT_W'(1)));
         ctrl[j].clear  = finish;
         ctrl[j].op     = op;
         ctrl[j].digit  = (j == 0) ? digit : '0;
      end

      if (j == 0) begin : g_first
         assign cin = '0;
      end else begin : g_rest
         assign cin = carries[j-1];
      end

      ttmi_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl[j]),
         .carry_below (cin),
         .carry_out   (carries[j]),
         .next_word   (snap_word[j]),
         .next_carry  (snap_carry[j])
      );
   end

   ttmi_drain #(
      .CELLS (CELLS)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (finish),
      .load_word  (snap_word),
      .load_carry (snap_carry),
      .load_last  (IDX_W'(word_count - CNT_W'(1))),
      .out_ready  (rsp.ready),
      .out_valid  (rsp.valid),
      .out_word   (rsp.word_value),
      .out_index  (rsp.word_index),
      .out_last   (rsp.last_word),
      .status     (drain_st)
   );

endmodule

FILE: rtl/ttmi_checker.sv
module ttmi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_is_final,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ttmi_pkg::IDX_W-1:0]    rsp_word_index,
   input logic                          rsp_last_word
);
   import ttmi_pkg::*;

`include "text_to_multiword_integer_core_macros.svh"

   logic req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // A result offered must stay offered until it is taken.
   `TTMI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")

   // A final character always leaves words waiting in the next cycle.
   `TTMI_ASSERT_NEXT(a_final_loads, req_xfer && req_is_final, rsp_valid,
                     "final character produced no words")

   // Words of one value follow without a gap and in rising order.
   `TTMI_ASSERT_NEXT(a_no_gap, rsp_xfer && !rsp_last_word, rsp_valid,
                     "gap inside a value")
   `TTMI_ASSERT_NEXT(a_index_step, rsp_xfer && !rsp_last_word,
                     rsp_word_index == IDX_W'($past(rsp_word_index) + 3'd1),
                     "word index did not advance")

   // Each value starts at its least significant word.
   `TTMI_ASSERT_NEXT(a_index_start, req_xfer && req_is_final, rsp_word_index == '0,
                     "value did not start at word zero")

endmodule

bind text_to_multiword_integer_core ttmi_checker u_ttmi_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_is_final   (req.is_final),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_word_index (rsp.word_index),
   .rsp_last_word  (rsp.last_word)
);

FILE: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ttmi_pkg::*;

   localparam int MODEL_WORDS   = DEFAULT_WORDS;
   localparam int VALUE_W       = WORD_W * MAX_OUT_WORDS;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_CHARS  = 480;
   localparam int SETTLE_CYCLES = 12;
   localparam int TIMEOUT_NS    = 2_400_000;

   // Word-count settings visited first, extremes and out-of-range values among them.
   localparam logic [CFG_W-1:0] WORD_SWEEP [7] = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd9, 4'd2, 4'd7};

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              fin;
      logic              typed;
      logic [WORD_W-1:0] low_word;
   } text_row_type;

   typedef struct packed {
      logic [WORD_W-1:0] word_value;
      logic [IDX_W-1:0]  word_index;
      logic              last_word;
   } word_beat_type;

   // A typed row expects its low word as given and every other word zero.
   localparam text_row_type DIRECTED_TEXT [DIRECTED_ROWS] = '{
      '{CHAR_ZERO,    1'b1, 1'b1, 32'd0},
      '{"9",          1'b1, 1'b1, 32'd9},
      '{CHAR_ZERO,    1'b0, 1'b0, 32'd0},
      '{CHAR_LOWER_X, 1'b1, 1'b1, 32'd0},
      '{CHAR_ZERO,    1'b0, 1'b0, 32'd0},
      '{CHAR_UPPER_X, 1'b0, 1'b0, 32'd0},
      '{CHAR_UPPER_F, 1'b1, 1'b1, 32'd15},
      '{"1",          1'b0, 1'b0, 32'd0},
      '{CHAR_LOWER_X, 1'b0, 1'b0, 32'd0},
      '{"2",          1'b1, 1'b1, 32'd12},
      '{CHAR_ZERO,    1'b0, 1'b0, 32'd0},
      '{CHAR_ZERO,    1'b0, 1'b0, 32'd0},
      '{CHAR_UPPER_X, 1'b0, 1'b0, 32'd0},
      '{"5",          1'b1, 1'b1, 32'd5},
      '{8'h00,        1'b0, 1'b0, 32'd0},
      '{8'hFF,        1'b0, 1'b0, 32'd0},
      '{"/",          1'b0, 1'b0, 32'd0},
      '{":",          1'b1, 1'b1, 32'd0},
      '{CHAR_ZERO,    1'b0, 1'b0, 32'd0},
      '{CHAR_LOWER_X, 1'b0, 1'b0, 32'd0},
      '{CHAR_LOWER_A, 1'b0, 1'b0, 32'd0},
      '{CHAR_LOWER_F, 1'b0, 1'b0, 32'd0},
      '{"G",          1'b0, 1'b0, 32'd0},
      '{CHAR_UPPER_A, 1'b1, 1'b0, 32'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable;
   logic [CFG_W-1:0]  csr_write_data;
   logic              typed_pending;
   logic [WORD_W-1:0] typed_low_word;
   bit                calm;

   // Shadow copy of the converter state.
   logic [VALUE_W-1:0] acc_value;
   logic [1:0]         char_count;
   logic               hex_active;
   logic               lead_zero;
   logic [CFG_W-1:0]   words_cfg;

   word_beat_type expected_words [$];
   int unsigned   fails;
   int unsigned   chars_sent;
   int unsigned   words_seen;
   int unsigned   settings_used;

   ttmi_req_if req_ch ();
   ttmi_rsp_if rsp_ch ();

   text_to_multiword_integer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Folds one accepted character into the shadow value and queues the words it releases.
   task automatic absorb_char(input logic [CHAR_W-1:0] ch, input logic fin, input logic typed,
                              input logic [WORD_W-1:0] low_word);
      int                 span;
      int                 nib;
      logic [VALUE_W-1:0] keep;
      word_beat_type      beat;
      span = (words_cfg == '0) ? 1 : int'(words_cfg);
      if (span > MODEL_WORDS) span = MODEL_WORDS;
      if (span > MAX_OUT_WORDS) span = MAX_OUT_WORDS;
      keep = '1;
      keep = keep >> (VALUE_W - WORD_W * span);
      // Words above the current count are dropped before anything else happens.
      acc_value = acc_value & keep;
      nib = -1;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) nib = int'(ch - CHAR_ZERO);
      else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) nib = int'(ch - CHAR_UPPER_A) + 10;
      else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) nib = int'(ch - CHAR_LOWER_A) + 10;
      if (char_count == 2'd1 && lead_zero && (ch == CHAR_LOWER_X || ch == CHAR_UPPER_X)) begin
         hex_active = 1'b1;
      end else if (hex_active) begin
         if (nib >= 0) acc_value = ((acc_value << 4) | VALUE_W'(nib)) & keep;
      end else begin
         if (char_count == 2'd0) lead_zero = (ch == CHAR_ZERO);
         if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            acc_value = (acc_value * VALUE_W'(10) + VALUE_W'(nib)) & keep;
      end
      if (char_count != 2'd2) char_count = char_count + 2'd1;
      if (fin) begin
         for (int j = 0; j < span; j++) begin
            if (typed) beat.word_value = (j == 0) ? low_word : '0;
            else beat.word_value = acc_value[WORD_W*j +: WORD_W];
            beat.word_index = IDX_W'(j);
            beat.last_word  = (j == span - 1);
            expected_words.push_back(beat);
         end
         acc_value  = '0;
         char_count = '0;
         hex_active = 1'b0;
         lead_zero  = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      word_beat_type want;
      if (reset) begin
         acc_value  = '0;
         char_count = '0;
         hex_active = 1'b0;
         lead_zero  = 1'b0;
         words_cfg  = RESET_ACTIVE_WORDS;
      end else begin
         if (csr_write_enable) words_cfg = csr_write_data;
         if (req_ch.valid && req_ch.ready)
            absorb_char(req_ch.character, req_ch.is_final, typed_pending, typed_low_word);
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_seen++;
            if (expected_words.size() == 0) begin
               $error("unexpected word: word_value %h word_index %0d last_word %0b",
                      rsp_ch.word_value, rsp_ch.word_index, rsp_ch.last_word);
               fails++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.word_value !== want.word_value) begin
                  $error("word_value mismatch: expected %h, actual %h",
                         want.word_value, rsp_ch.word_value);
                  fails++;
               end
               if (rsp_ch.word_index !== want.word_index) begin
                  $error("word_index mismatch: expected %0d, actual %0d",
                         want.word_index, rsp_ch.word_index);
                  fails++;
               end
               if (rsp_ch.last_word !== want.last_word) begin
                  $error("last_word mismatch: expected %0b, actual %0b",
                         want.last_word, rsp_ch.last_word);
                  fails++;
               end
            end
         end
      end
   end

   // Receiving side: a random stall before each transfer, none while calm.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic fin, input logic typed,
                            input logic [WORD_W-1:0] low_word);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.character <= ch;
      req_ch.is_final  <= fin;
      typed_pending    <= typed;
      typed_low_word   <= low_word;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
   endtask

   // One whole number string: mostly well-formed decimal or hex, the rest noise.
   task automatic send_number_text();
      logic [CHAR_W-1:0] text [$];
      logic [CHAR_W-1:0] ch;
      int                kind;
      int                len;
      int                pick;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
         repeat (len) begin
            if ($urandom_range(0, 9) == 0) ch = CHAR_W'($urandom_range(0, 255));
            else ch = CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
            text.push_back(ch);
         end
      end else if (kind <= 7) begin
         text.push_back(CHAR_ZERO);
         text.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 70) : $urandom_range(0, 16);
         repeat (len) begin
            pick = $urandom_range(0, 23);
            // Strings of F push every bit of the value high before it wraps.
            if (kind == 7) ch = pick[0] ? CHAR_UPPER_F : CHAR_LOWER_F;
            else if (pick < 10) ch = CHAR_ZERO + CHAR_W'(pick);
            else if (pick < 16) ch = CHAR_UPPER_A + CHAR_W'(pick - 10);
            else if (pick < 22) ch = CHAR_LOWER_A + CHAR_W'(pick - 16);
            else ch = CHAR_W'($urandom_range(0, 255));
            text.push_back(ch);
         end
      end else begin
         len = $urandom_range(1, 6);
         repeat (len) text.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, '0);
   endtask

   task automatic set_word_count(input logic [CFG_W-1:0] count);
      // Wait on a clock edge first, so that words queued at the last transfer are seen.
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int phase;
      req_ch.valid     <= 1'b0;
      req_ch.character <= '0;
      req_ch.is_final  <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      typed_pending    <= 1'b0;
      typed_low_word   <= '0;
      calm = 1'b0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_TEXT[i])
         send_char(DIRECTED_TEXT[i].ch, DIRECTED_TEXT[i].fin, DIRECTED_TEXT[i].typed,
                   DIRECTED_TEXT[i].low_word);
      req_ch.valid <= 1'b0;

      phase = 0;
      while (chars_sent < DIRECTED_ROWS + RANDOM_CHARS) begin
         if (phase < $size(WORD_SWEEP)) set_word_count(WORD_SWEEP[phase]);
         else set_word_count(CFG_W'($urandom_range(0, 15)));
         calm = (phase % 4 == 3);
         repeat ($urandom_range(1, 4)) send_number_text();
         // Leave a string unfinished now and then, so the next word count lands mid-string.
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) begin
               send_char(CHAR_ZERO, 1'b0, 1'b0, '0);
               send_char(CHAR_LOWER_X, 1'b0, 1'b0, '0);
            end
            repeat ($urandom_range(1, 5))
               send_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0, 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
         phase++;
      end
      calm = 1'b0;

      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d characters over %0d word-count settings, checked %0d result words.",
               chars_sent, settings_used, words_seen);
      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches found.", fails);
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Timed out with %0d words still expected.", expected_words.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: text_to_multiword_integer_core.f
+incdir+rtl
rtl/ttmi_pkg.sv
rtl/ttmi_channels.sv
rtl/ttmi_cell.sv
rtl/ttmi_drain.sv
rtl/text_to_multiword_integer_core.sv
rtl/ttmi_checker.sv
sim/tb_top.sv
